FILE: rtl/bhq_pkg.sv
// Package for the binary min-heap queue: field widths, request and status
// codes, and the default sizing. Depends on nothing.
package bhq_pkg;

  localparam int REQ_W     = 2;
  localparam int KEY_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 7;

  localparam int DEF_DEPTH     = 64;
  localparam int DEF_KEY_WIDTH = 32;

  typedef logic [REQ_W-1:0]    req_code_t;
  typedef logic [STATUS_W-1:0] status_t;

  // A request code other than push or pop reads the root like a peek.
  localparam req_code_t REQ_PUSH = 2'd0;
  localparam req_code_t REQ_POP  = 2'd1;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

FILE: rtl/bhq_req_if.sv
// Request channel of the heap queue: valid, ready, request code and key.
// Depends on bhq_pkg.
interface bhq_req_if import bhq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  req_code_t            req_type;
  logic [KEY_W-1:0]     key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink (input valid, input req_type, input key, output ready);
endinterface

FILE: rtl/bhq_rsp_if.sv
// Result channel of the heap queue: valid, ready, status, minimum and count.
// Depends on bhq_pkg.
interface bhq_rsp_if import bhq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [KEY_W-1:0]     min_key;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (output valid, output status, output min_key, output entry_count,
                  input ready);
  modport sink (input valid, input status, input min_key, input entry_count,
                output ready);
endinterface

FILE: rtl/bhq_cfg_if.sv
// Configuration write channel of the heap queue: valid, ready and the
// key_signed register value. Depends on nothing.
interface bhq_cfg_if ();
  logic valid;
  logic ready;
  logic key_signed;

  modport source (output valid, output key_signed, input ready);
  modport sink (input valid, input key_signed, output ready);
endinterface

FILE: rtl/binary_min_heap_queue.sv
// Binary min-heap priority queue top level: request, result and configuration
// channels, the sift sequencer and the key store. Depends on bhq_pkg,
// bhq_req_if, bhq_rsp_if, bhq_cfg_if and bhq_ram.
//
// A request transaction on in_chan pushes a key, pops the minimum or peeks at
// it. Each request produces exactly one result transaction on out_chan with a
// status, the relevant minimum and the entry count after the request.
// cfg_chan writes key_signed, which selects unsigned or two's complement key
// order; it is always ready and must only be written while the queue is idle.
// Keys live in a memory with two read ports and one write port. Each level of
// a sift-up or sift-down reads the parent or both children, then compares and
// writes back. A push sifts up from the new last entry; a pop reads the last
// entry, moves it to the root and sifts it down; a peek or a refused request
// goes straight to the result step. One request
// is processed at a time. The result sits in an output register, so a new
// request is accepted while the previous result waits; if that result has not
// been taken when the next one is ready, the sequencer holds until it is.
// After reset the queue is empty, key_signed is zero and no result is pending.
module binary_min_heap_queue import bhq_pkg::*; #(
  parameter int DEPTH     = DEF_DEPTH,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  bhq_req_if.sink   in_chan,
  bhq_rsp_if.source out_chan,
  bhq_cfg_if.sink   cfg_chan
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_DN_LAST = 3'd3;
  localparam logic [2:0] S_DN_RD   = 3'd4;
  localparam logic [2:0] S_DN_CMP  = 3'd5;
  localparam logic [2:0] S_FIN     = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        limit_r, limit_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [KEY_WIDTH-1:0] mov_r, mov_nxt;
  logic [KEY_WIDTH-1:0] root_r, root_nxt;
  logic [KEY_WIDTH-1:0] res_min_r, res_min_nxt;
  status_t              res_status_r, res_status_nxt;
  logic                 is_push_r, is_push_nxt;
  logic                 key_signed_r;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [KEY_W-1:0]     out_min_r, out_min_nxt;
  logic [CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [KEY_WIDTH-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

  logic                 in_acc;
  logic [63:0]          key_ext;
  logic [KEY_WIDTH-1:0] key_k;
  logic [63:0]          min_ext;
  logic [AW-1:0]        parent;
  logic [IW-1:0]        left_i, right_i, limit_i;
  logic                 has_left, has_right;
  logic [KEY_WIDTH-1:0] child_val;
  logic [AW-1:0]        child_pos;

  function automatic logic key_less(input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b,
                                    input logic                 sgn);
    logic [KEY_WIDTH-1:0] flip;
    flip = '0;
    flip[KEY_WIDTH-1] = sgn;
    return (a ^ flip) < (b ^ flip);
  endfunction

  bhq_ram #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH),
    .AW        (AW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.min_key     = out_min_r;
  assign out_chan.entry_count = out_cnt_r;

  assign key_ext = 64'(in_chan.key);
  assign key_k   = key_ext[KEY_WIDTH-1:0];
  assign min_ext = 64'(is_push_r ? root_r : res_min_r);

  assign parent    = (pos_r - AW'(1)) >> 1;
  assign left_i    = {1'b0, pos_r, 1'b1};
  assign right_i   = left_i + IW'(1);
  assign limit_i   = IW'(limit_r);
  assign has_left  = left_i < limit_i;
  assign has_right = right_i < limit_i;

  always_comb begin
    if (has_right && !key_less(ram_rdata_a, ram_rdata_b, key_signed_r)) begin
      child_val = ram_rdata_b;
      child_pos = right_i[AW-1:0];
    end else begin
      child_val = ram_rdata_a;
      child_pos = left_i[AW-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    limit_nxt      = limit_r;
    pos_nxt        = pos_r;
    mov_nxt        = mov_r;
    res_min_nxt    = res_min_r;
    res_status_nxt = res_status_r;
    is_push_nxt    = is_push_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_min_nxt    = out_min_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = mov_r;
    ram_raddr_a    = pos_r;
    ram_raddr_b    = pos_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          is_push_nxt    = (in_chan.req_type == REQ_PUSH);
          res_status_nxt = ST_DONE;
          res_min_nxt    = root_r;
          if (in_chan.req_type == REQ_PUSH) begin
            if (count_r >= CW'(DEPTH)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_FIN;
            end else begin
              mov_nxt   = key_k;
              pos_nxt   = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
              state_nxt = S_UP_RD;
            end
          end else if (count_r == '0) begin
            res_status_nxt = ST_EMPTY;
            res_min_nxt    = '0;
            state_nxt      = S_FIN;
          end else if (in_chan.req_type == REQ_POP) begin
            count_nxt   = count_r - CW'(1);
            limit_nxt   = count_r - CW'(1);
            ram_raddr_a = AW'(count_r - CW'(1));
            state_nxt   = (count_r == CW'(1)) ? S_FIN : S_DN_LAST;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          ram_raddr_a = parent;
          state_nxt   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (key_less(mov_r, ram_rdata_a, key_signed_r)) begin
          ram_wdata = ram_rdata_a;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DN_LAST: begin
        mov_nxt   = ram_rdata_a;
        pos_nxt   = '0;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        if (!has_left) begin
          ram_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          ram_raddr_a = left_i[AW-1:0];
          ram_raddr_b = has_right ? right_i[AW-1:0] : left_i[AW-1:0];
          state_nxt   = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        ram_we = 1'b1;
        if (key_less(child_val, mov_r, key_signed_r)) begin
          ram_wdata = child_val;
          pos_nxt   = child_pos;
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_min_nxt    = min_ext[KEY_W-1:0];
          out_cnt_nxt    = CNT_OUT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign root_nxt = (ram_we && ram_waddr == '0) ? ram_wdata : root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      key_signed_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        key_signed_r <= cfg_chan.key_signed;
      end
    end
  end

  always_ff @(posedge clk) begin
    limit_r      <= limit_nxt;
    pos_r        <= pos_nxt;
    mov_r        <= mov_nxt;
    root_r       <= root_nxt;
    res_min_r    <= res_min_nxt;
    res_status_r <= res_status_nxt;
    is_push_r    <= is_push_nxt;
    out_status_r <= out_status_nxt;
    out_min_r    <= out_min_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("Entry count exceeds the heap depth.");

  a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CW'(ram_waddr) < count_r))
    else $error("Store write lies outside the occupied entries.");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.req_type == REQ_POP && count_r != '0)
      |=> (count_r == $past(count_r) - CW'(1)))
    else $error("Pop transaction did not decrement the entry count.");

  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && (!out_valid_r || out_chan.ready)) |=> out_valid_r)
    else $error("Finished request produced no result transaction.");
`endif

endmodule

FILE: rtl/bhq_ram.sv
// Heap key store: one write port and two read ports with registered read
// data. Depends on nothing.
module bhq_ram #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32,
  parameter int AW        = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [KEY_WIDTH-1:0] wdata,
  input  logic [AW-1:0]        raddr_a,
  input  logic [AW-1:0]        raddr_b,
  output logic [KEY_WIDTH-1:0] rdata_a,
  output logic [KEY_WIDTH-1:0] rdata_b
);

  logic [KEY_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: test/tb.sv
// Self-checking testbench for binary_min_heap_queue: drives push, pop and peek
// requests under both key orders and checks every result against a heap predictor.
// Depends on bhq_pkg, bhq_req_if, bhq_rsp_if, bhq_cfg_if and the queue RTL.
module tb;
  import bhq_pkg::*;

  localparam int HEAP_DEPTH = DEF_DEPTH;
  localparam req_code_t REQ_PEEK  = 2'd2;
  localparam req_code_t REQ_SPARE = 2'd3;

  typedef struct packed {
    status_t              status;
    logic [KEY_W-1:0]     min_key;
    logic [CNT_OUT_W-1:0] entry_count;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bhq_req_if req_bus ();
  bhq_rsp_if rsp_bus ();
  bhq_cfg_if cfg_bus ();

  binary_min_heap_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_bus),
    .out_chan (rsp_bus),
    .cfg_chan (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [KEY_W-1:0] heap_keys [HEAP_DEPTH];
  int               heap_size = 0;
  bit               order_signed = 1'b0;
  heap_result_t     pending_results [$];
  int               fail_count = 0;
  bit               req_active = 1'b0;
  int               burst_left = 0;
  int unsigned      ready_cycle = 0;
  int               stall_mode = 0;

  function automatic bit key_lt(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    if (order_signed) begin
      return $signed(a) < $signed(b);
    end
    return a < b;
  endfunction

  function automatic void swap_keys(int i, int j);
    logic [KEY_W-1:0] t;
    t = heap_keys[i];
    heap_keys[i] = heap_keys[j];
    heap_keys[j] = t;
  endfunction

  function automatic void predict_request(req_code_t req, logic [KEY_W-1:0] key);
    heap_result_t res;
    int pos;
    int parent;
    int left;
    int child;
    res.status = ST_DONE;
    res.min_key = '0;
    if (req == REQ_PUSH) begin
      if (heap_size >= HEAP_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        heap_keys[heap_size] = key;
        pos = heap_size;
        while (pos != 0) begin
          parent = (pos - 1) / 2;
          if (!key_lt(heap_keys[pos], heap_keys[parent])) break;
          swap_keys(pos, parent);
          pos = parent;
        end
        heap_size++;
      end
      res.min_key = heap_keys[0];
    end else if (heap_size == 0) begin
      res.status = ST_EMPTY;
    end else if (req == REQ_POP) begin
      res.min_key = heap_keys[0];
      heap_size--;
      heap_keys[0] = heap_keys[heap_size];
      pos = 0;
      forever begin
        left = 2 * pos + 1;
        if (left + 1 < heap_size) begin
          child = key_lt(heap_keys[left], heap_keys[left + 1]) ? left : left + 1;
        end else if (left < heap_size) begin
          child = left;
        end else begin
          break;
        end
        if (!key_lt(heap_keys[child], heap_keys[pos])) break;
        swap_keys(pos, child);
        pos = child;
      end
    end else begin
      res.min_key = heap_keys[0];
    end
    res.entry_count = CNT_OUT_W'(heap_size);
    pending_results.push_back(res);
  endfunction

  function automatic void check_result();
    heap_result_t exp_res;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result transaction: status %0d min_key %h count %0d",
               $time, rsp_bus.status, rsp_bus.min_key, rsp_bus.entry_count);
      fail_count++;
      return;
    end
    exp_res = pending_results.pop_front();
    if (rsp_bus.status !== exp_res.status) begin
      $display("%0t: status mismatch: expected %0d actual %0d",
               $time, exp_res.status, rsp_bus.status);
      fail_count++;
    end
    if (rsp_bus.min_key !== exp_res.min_key) begin
      $display("%0t: min_key mismatch: expected %h actual %h",
               $time, exp_res.min_key, rsp_bus.min_key);
      fail_count++;
    end
    if (rsp_bus.entry_count !== exp_res.entry_count) begin
      $display("%0t: entry_count mismatch: expected %0d actual %0d",
               $time, exp_res.entry_count, rsp_bus.entry_count);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      check_result();
    end
    ready_cycle <= ready_cycle + 1;
    if (ready_cycle[5:0] == 6'd0) begin
      stall_mode <= $urandom_range(0, 3);
    end
    case (stall_mode)
      0: rsp_bus.ready <= 1'b1;
      1: rsp_bus.ready <= 1'($urandom_range(0, 1));
      2: rsp_bus.ready <= (ready_cycle % 3 == 0);
      default: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic send_request(req_code_t req, logic [KEY_W-1:0] key);
    int gap;
    req_bus.valid <= 1'b1;
    req_bus.req_type <= req;
    req_bus.key <= key;
    req_active = 1'b1;
    do @(posedge clk); while (!req_bus.ready);
    predict_request(req, key);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = $urandom_range(1, 8);
      req_bus.valid <= 1'b0;
      req_active = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    if (req_active) begin
      req_bus.valid <= 1'b0;
      req_active = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_key_order(bit is_signed);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.key_signed <= is_signed;
    do @(posedge clk); while (!cfg_bus.ready);
    order_signed = is_signed;
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    case ($urandom_range(0, 3))
      0: return KEY_W'($urandom_range(0, 7));
      1: return 32'h7FFF_FFF8 + KEY_W'($urandom_range(0, 15));
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_queue();
    send_request(REQ_POP, 32'hFFFF_FFFF);
    send_request(REQ_PEEK, 32'h0);
    send_request(REQ_SPARE, 32'h1234_5678);
  endtask

  task automatic test_key_order(bit is_signed);
    write_key_order(is_signed);
    send_request(REQ_PUSH, 32'h8000_0000);
    send_request(REQ_PUSH, 32'h7FFF_FFFF);
    send_request(REQ_PUSH, 32'hFFFF_FFFF);
    send_request(REQ_PUSH, 32'h0000_0000);
    send_request(REQ_PUSH, 32'h7FFF_FFFF);
    send_request(is_signed ? REQ_SPARE : REQ_PEEK, 32'h0);
    repeat (5) send_request(REQ_POP, 32'h0);
    send_request(REQ_POP, 32'h0);
  endtask

  task automatic test_full_heap(bit is_signed);
    write_key_order(is_signed);
    repeat (HEAP_DEPTH) send_request(REQ_PUSH, random_key());
    send_request(REQ_PUSH, 32'h0000_0000);
    send_request(REQ_PUSH, 32'hFFFF_FFFF);
    send_request(REQ_PEEK, 32'h0);
    repeat (HEAP_DEPTH + 1) send_request(REQ_POP, $urandom);
  endtask

  task automatic test_random_mix(bit is_signed, int count, int push_pct, int pop_pct);
    int pick;
    write_key_order(is_signed);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < push_pct) begin
        send_request(REQ_PUSH, random_key());
      end else if (pick < push_pct + pop_pct) begin
        send_request(REQ_POP, $urandom);
      end else begin
        send_request($urandom_range(0, 1) ? REQ_PEEK : REQ_SPARE, $urandom);
      end
    end
  endtask

  initial begin
    int guard;
    rst_n <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.req_type <= REQ_PUSH;
    req_bus.key <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.key_signed <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_key_order(1'b0);
    test_key_order(1'b1);
    test_full_heap(1'b0);
    test_full_heap(1'b1);
    test_random_mix(1'b0, 130, 50, 35);
    test_random_mix(1'b1, 130, 70, 20);
    test_random_mix(1'b0, 130, 30, 55);
    test_random_mix(1'b1, 130, 50, 30);

    if (req_active) begin
      req_bus.valid <= 1'b0;
      req_active = 1'b0;
    end
    guard = 0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      fail_count++;
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
